// ===== hw/rtl/era_pkg.sv =====
// ----------------------------------------------------------------------------
// era_pkg: shared types and constants of the epoch reorder release block
// Item kinds, result status codes, the queue item and the expected-key view.
// ----------------------------------------------------------------------------
`default_nettype none

package era_pkg;

	localparam int SEQ_W      = 32;
	localparam int SHARD_W    = 3;
	localparam int HANDLE_W   = 8;
	localparam int COUNT_W    = 4;
	// Widest row and column index over the parameter ranges (up to 64 each).
	localparam int ROW_W_MAX  = 6;
	localparam int COL_W_MAX  = 6;
	localparam int RESULT_CAP = 64;
	localparam int CNT_W      = 7;

	typedef enum logic [1:0] {
		ST_RELEASED  = 2'd0,
		ST_STALE     = 2'd1,
		ST_FAR       = 2'd2,
		ST_BAD_SHARD = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		IT_PARK    = 2'd0,
		IT_REJECT  = 2'd1,
		IT_RELEASE = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t            kind;
		status_t               status;
		logic [SEQ_W-1:0]      seq;
		logic [SHARD_W-1:0]    shard;
		logic [HANDLE_W-1:0]   handle;
		logic [ROW_W_MAX-1:0]  row;
		logic [COL_W_MAX-1:0]  col;
	} q_item_t;

	// Expected key and shard count as seen by the classifier.
	typedef struct packed {
		logic [SEQ_W-1:0]      seq;
		logic [COUNT_W-1:0]    shard;
		logic [ROW_W_MAX-1:0]  row;
		logic [COUNT_W-1:0]    count;
	} key_t;

endpackage

`default_nettype wire

// ===== hw/rtl/era_front.sv =====
// ----------------------------------------------------------------------------
// era_front: request acceptance and classification
// Checks each request against the expected key and queues it as a park,
// a reject or a release for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module era_front #(
	parameter int MAX_SHARDS    = 8,
	parameter int WINDOW_EPOCHS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [era_pkg::SEQ_W-1:0]    seq_no,
	input  wire logic [era_pkg::SHARD_W-1:0]  shard_id,
	input  wire logic [era_pkg::HANDLE_W-1:0] handle,
	input  wire era_pkg::key_t                key,
	input  wire logic                         q_full,
	input  wire logic                         drain_done,
	output logic                              push,
	output era_pkg::q_item_t                  push_item
);
	import era_pkg::*;

	localparam int RW = (WINDOW_EPOCHS > 1) ? $clog2(WINDOW_EPOCHS) : 1;
	localparam int SW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;

	logic              pend_q;
	logic [SEQ_W-1:0]  key_dist;
	logic [RW:0]       row_sum;
	logic [RW-1:0]     row;
	logic [SW-1:0]     col;
	logic [COUNT_W-1:0] shard_x;

	// While a release is being drained the expected key is moving, so the
	// next request waits for the run to finish.
	assign busy = q_full || pend_q;
	assign push = start && !busy;

	always_comb begin
		shard_x  = COUNT_W'(shard_id);
		key_dist = seq_no - key.seq;
		row_sum  = {1'b0, key.row[RW-1:0]} + {1'b0, key_dist[RW-1:0]};
		if (row_sum >= (RW+1)'(WINDOW_EPOCHS)) begin
			row_sum = row_sum - (RW+1)'(WINDOW_EPOCHS);
		end
		row = row_sum[RW-1:0];
		col = SW'({{SW{1'b0}}, shard_id});

		push_item.kind   = IT_PARK;
		push_item.status = ST_RELEASED;
		push_item.seq    = seq_no;
		push_item.shard  = shard_id;
		push_item.handle = handle;
		push_item.row    = ROW_W_MAX'(row);
		push_item.col    = COL_W_MAX'(col);

		priority if (shard_x >= key.count) begin
			push_item.kind   = IT_REJECT;
			push_item.status = ST_BAD_SHARD;
		end else if (key_dist[SEQ_W-1] || (key_dist == '0 && shard_x < key.shard)) begin
			push_item.kind   = IT_REJECT;
			push_item.status = ST_STALE;
		end else if (key_dist >= SEQ_W'(WINDOW_EPOCHS)) begin
			push_item.kind   = IT_REJECT;
			push_item.status = ST_FAR;
		end else if (key_dist == '0 && shard_x == key.shard) begin
			push_item.kind   = IT_RELEASE;
		end else begin
			push_item.kind   = IT_PARK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= (pend_q && !drain_done) || (push && push_item.kind == IT_RELEASE);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/era_queue.sv =====
// ----------------------------------------------------------------------------
// era_queue: two-entry item queue
// Decouples the classifier from the release engine.
// ----------------------------------------------------------------------------
`default_nettype none

module era_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire era_pkg::q_item_t push_item,
	input  wire logic             pop,
	output era_pkg::q_item_t      head,
	output logic                  full,
	output logic                  empty
);
	import era_pkg::*;

	q_item_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("item pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("item popped from an empty queue");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 2'd1)
		else $error("queue fill count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/era_back.sv =====
// ----------------------------------------------------------------------------
// era_back: park store and in-order release engine
// Owns the expected key, the shard count, the slot valid bits and the handle
// memory; parks items, emits rejects and drains released runs.
// ----------------------------------------------------------------------------
`default_nettype none

module era_back #(
	parameter int MAX_SHARDS    = 8,
	parameter int WINDOW_EPOCHS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire era_pkg::q_item_t             head,
	input  wire logic                         q_empty,
	output logic                              pop,
	input  wire logic                         cfg_we,
	input  wire logic [era_pkg::COUNT_W-1:0]  cfg_data,
	output era_pkg::key_t                     key,
	output logic                              drain_done,
	output logic                              idle,
	output logic                              res_valid,
	output logic [era_pkg::HANDLE_W-1:0]      res_handle,
	output logic [era_pkg::SEQ_W-1:0]         res_seq,
	output logic [era_pkg::SHARD_W-1:0]       res_shard,
	output era_pkg::status_t                  res_status,
	output logic                              res_last
);
	import era_pkg::*;

	localparam int RW    = (WINDOW_EPOCHS > 1) ? $clog2(WINDOW_EPOCHS) : 1;
	localparam int SW    = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
	localparam int SLOTS = WINDOW_EPOCHS * MAX_SHARDS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'b01,
		BK_DRAIN = 2'b10
	} bk_state_t;

	bk_state_t           state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [SEQ_W-1:0]    exp_seq_q;
	logic [COUNT_W-1:0]  exp_shard_q;
	logic [RW-1:0]       exp_row_q;
	logic [COUNT_W-1:0]  count_q;
	logic [MAX_SHARDS-1:0] valid_q [WINDOW_EPOCHS];
	logic [HANDLE_W-1:0] mem [SLOTS];
	logic [HANDLE_W-1:0] rd_q;

	logic [SW-1:0]       cur_col, nx_col, park_col;
	logic [RW-1:0]       nx_row, inc_row, park_row;
	logic [COUNT_W-1:0]  nx_shard;
	logic [SEQ_W-1:0]    nx_seq;
	logic [AW-1:0]       nx_addr, park_addr;
	logic                seq_adv, nx_valid, more;
	logic [CNT_W-1:0]    n_now;
	logic [COUNT_W-1:0]  cfg_count;

	logic                em, step, park_we, rd_en;
	logic [HANDLE_W-1:0] em_handle;
	logic [SEQ_W-1:0]    em_seq;
	logic [SHARD_W-1:0]  em_shard;
	status_t             em_status;
	logic                em_last;

	assign key.seq   = exp_seq_q;
	assign key.shard = exp_shard_q;
	assign key.row   = ROW_W_MAX'(exp_row_q);
	assign key.count = count_q;
	assign idle      = (state_q == BK_IDLE);

	// Successor of the expected key; the old row is retired when the
	// sequence moves on, so a slot in that row cannot count as parked.
	always_comb begin
		cur_col  = SW'({{SW{1'b0}}, exp_shard_q});
		inc_row  = (exp_row_q == RW'(WINDOW_EPOCHS - 1)) ? '0 : exp_row_q + RW'(1);
		seq_adv  = ({1'b0, exp_shard_q} + 5'd1) >= {1'b0, count_q};
		nx_shard = seq_adv ? '0 : exp_shard_q + COUNT_W'(1);
		nx_seq   = seq_adv ? exp_seq_q + SEQ_W'(1) : exp_seq_q;
		nx_row   = seq_adv ? inc_row : exp_row_q;
		nx_col   = SW'({{SW{1'b0}}, nx_shard});
		nx_addr  = AW'(nx_row) * AW'(MAX_SHARDS) + AW'(nx_col);
		nx_valid = valid_q[nx_row][nx_col] && !(seq_adv && nx_row == exp_row_q);
		n_now    = (state_q == BK_DRAIN) ? cnt_q + CNT_W'(1) : CNT_W'(1);
		more     = nx_valid && (n_now < CNT_W'(RESULT_CAP));

		park_row  = head.row[RW-1:0];
		park_col  = head.col[SW-1:0];
		park_addr = AW'(park_row) * AW'(MAX_SHARDS) + AW'(park_col);

		cfg_count = cfg_data;
		if (cfg_count == '0) begin
			cfg_count = COUNT_W'(1);
		end
		if ({3'b000, cfg_count} > 7'(MAX_SHARDS)) begin
			cfg_count = COUNT_W'(MAX_SHARDS);
		end
	end

	always_comb begin
		pop        = 1'b0;
		em         = 1'b0;
		step       = 1'b0;
		park_we    = 1'b0;
		rd_en      = 1'b0;
		drain_done = 1'b0;
		state_d    = state_q;
		em_handle  = head.handle;
		em_seq     = exp_seq_q;
		em_shard   = exp_shard_q[SHARD_W-1:0];
		em_status  = ST_RELEASED;
		em_last    = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					unique case (head.kind)
						IT_PARK: begin
							park_we = 1'b1;
						end
						IT_REJECT: begin
							em        = 1'b1;
							em_seq    = head.seq;
							em_shard  = head.shard;
							em_status = head.status;
						end
						IT_RELEASE: begin
							em         = 1'b1;
							step       = 1'b1;
							em_last    = !more;
							rd_en      = more;
							drain_done = !more;
							state_d    = more ? BK_DRAIN : BK_IDLE;
						end
						default: begin
						end
					endcase
				end
			end
			BK_DRAIN: begin
				em         = 1'b1;
				step       = 1'b1;
				em_handle  = rd_q;
				em_last    = !more;
				rd_en      = more;
				drain_done = !more;
				state_d    = more ? BK_DRAIN : BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			exp_seq_q   <= SEQ_W'(1);
			exp_shard_q <= '0;
			exp_row_q   <= RW'(1 % WINDOW_EPOCHS);
			count_q     <= COUNT_W'(1);
			valid_q     <= '{default: '0};
			res_valid   <= 1'b0;
		end else if (cfg_we) begin
			count_q   <= cfg_count;
			res_valid <= 1'b0;
			if (exp_shard_q >= cfg_count) begin
				valid_q[exp_row_q] <= '0;
				exp_seq_q          <= exp_seq_q + SEQ_W'(1);
				exp_shard_q        <= '0;
				exp_row_q          <= inc_row;
			end
		end else begin
			state_q   <= state_d;
			res_valid <= em;
			if (park_we) begin
				valid_q[park_row][park_col] <= 1'b1;
			end
			if (step) begin
				if (seq_adv) begin
					valid_q[exp_row_q] <= '0;
				end else begin
					valid_q[exp_row_q][cur_col] <= 1'b0;
				end
				exp_seq_q   <= nx_seq;
				exp_shard_q <= nx_shard;
				exp_row_q   <= nx_row;
				cnt_q       <= more ? n_now : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (em) begin
			res_handle <= em_handle;
			res_seq    <= em_seq;
			res_shard  <= em_shard;
			res_status <= em_status;
			res_last   <= em_last;
		end
	end

	always_ff @(posedge clk) begin
		if (park_we) begin
			mem[park_addr] <= head.handle;
		end
		if (rd_en) begin
			rd_q <= mem[nx_addr];
		end
	end

`ifndef SYNTH
	a_drain_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DRAIN |-> valid_q[exp_row_q][cur_col])
		else $error("draining a slot that holds no parked item");
	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DRAIN |-> (cnt_q != '0 && cnt_q < CNT_W'(RESULT_CAP)))
		else $error("drain run count out of range");
	a_shard_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_shard_q < count_q) else $error("expected shard beyond shard count");
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status != ST_RELEASED) |-> res_last)
		else $error("rejected item not marked as its only result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_reorder_release.sv =====
// ----------------------------------------------------------------------------
// epoch_reorder_release: in-order release of epoch requests
// Top level joining the classifier, the item queue and the release engine.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A rejected or parked
// request passes the classifier in its accept cycle and the release engine in
// the next; the release engine registers a rejected result. A release shows
// its first result the same way and then one parked successor per cycle,
// each handle read from the slot memory in the cycle before; at most 64
// results follow one request and the rest stay parked. While a run drains,
// busy stays high, since the next request is classified against the key
// that the run leaves.
// Results are shown for one cycle with result_valid and cannot be held off.
// The shard count is written through cfg_valid and cfg_ready while idle;
// cfg_ready stays low while start is high.
`default_nettype none

module epoch_reorder_release #(
	parameter int MAX_SHARDS    = 8,
	parameter int WINDOW_EPOCHS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [era_pkg::SEQ_W-1:0]    seq_no,
	input  wire logic [era_pkg::SHARD_W-1:0]  shard_id,
	input  wire logic [era_pkg::HANDLE_W-1:0] handle,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [era_pkg::COUNT_W-1:0]  cfg_data,
	output logic                              result_valid,
	output logic [era_pkg::HANDLE_W-1:0]      out_handle,
	output logic [era_pkg::SEQ_W-1:0]         out_seq_no,
	output logic [era_pkg::SHARD_W-1:0]       out_shard_id,
	output logic [1:0]                        status,
	output logic                              last
);
	import era_pkg::*;

	key_t    key;
	q_item_t push_item, head;
	logic    push, pop, q_full, q_empty, drain_done, bk_idle;
	status_t res_status;

	// A request taken in the same cycle would be classified against the old key.
	assign cfg_ready = !busy && !start && q_empty && bk_idle;
	assign status    = res_status;

	era_front #(
		.MAX_SHARDS    (MAX_SHARDS),
		.WINDOW_EPOCHS (WINDOW_EPOCHS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.seq_no     (seq_no),
		.shard_id   (shard_id),
		.handle     (handle),
		.key        (key),
		.q_full     (q_full),
		.drain_done (drain_done),
		.push       (push),
		.push_item  (push_item)
	);

	era_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	era_back #(
		.MAX_SHARDS    (MAX_SHARDS),
		.WINDOW_EPOCHS (WINDOW_EPOCHS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.key        (key),
		.drain_done (drain_done),
		.idle       (bk_idle),
		.res_valid  (result_valid),
		.res_handle (out_handle),
		.res_seq    (out_seq_no),
		.res_shard  (out_shard_id),
		.res_status (res_status),
		.res_last   (last)
	);

endmodule

`default_nettype wire
